### rtl/epcs_pkg.sv
package epcs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned NAME_CHARS = 13;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MFG_LETTERS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_CODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEK_NUMBER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_NUMBER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_SIZE_INDEX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_HEAD        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_TAIL        = 3'd6;

    typedef struct packed {
        logic [23:0] mfg_letters;
        logic [15:0] product_code;
        logic [7:0]  week_number;
        logic [11:0] year_number;
        logic [5:0]  panel_size_index;
        logic [63:0] name_head;
        logic [39:0] name_tail;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       image_last;
    } t_result;

    // Panel width and height in cm; rows above 33 give 247 by 107
    function automatic logic [15:0] panel_size(input logic [5:0] row);
        logic [15:0] wh;
        unique case (row)
            6'd0:    wh = {8'd28,  8'd18};
            6'd1:    wh = {8'd30,  8'd18};
            6'd2:    wh = {8'd30,  8'd23};
            6'd3:    wh = {8'd33,  8'd21};
            6'd4:    wh = {8'd34,  8'd19};
            6'd5:    wh = {8'd34,  8'd27};
            6'd6:    wh = {8'd38,  8'd21};
            6'd7:    wh = {8'd41,  8'd23};
            6'd8:    wh = {8'd41,  8'd26};
            6'd9:    wh = {8'd44,  8'd25};
            6'd10:   wh = {8'd48,  8'd27};
            6'd11:   wh = {8'd47,  8'd30};
            6'd12:   wh = {8'd51,  8'd29};
            6'd13:   wh = {8'd52,  8'd29};
            6'd14:   wh = {8'd53,  8'd32};
            6'd15:   wh = {8'd58,  8'd35};
            6'd16:   wh = {8'd70,  8'd39};
            6'd17:   wh = {8'd70,  8'd39};
            6'd18:   wh = {8'd81,  8'd45};
            6'd19:   wh = {8'd82,  8'd46};
            6'd20:   wh = {8'd86,  8'd49};
            6'd21:   wh = {8'd89,  8'd50};
            6'd22:   wh = {8'd93,  8'd52};
            6'd23:   wh = {8'd95,  8'd54};
            6'd24:   wh = {8'd102, 8'd57};
            6'd25:   wh = {8'd104, 8'd58};
            6'd26:   wh = {8'd108, 8'd60};
            6'd27:   wh = {8'd110, 8'd62};
            6'd28:   wh = {8'd121, 8'd68};
            6'd29:   wh = {8'd143, 8'd80};
            6'd30:   wh = {8'd165, 8'd93};
            6'd31:   wh = {8'd190, 8'd107};
            6'd32:   wh = {8'd204, 8'd115};
            6'd33:   wh = {8'd216, 8'd122};
            default: wh = {8'd247, 8'd107};
        endcase
        return wh;
    endfunction

endpackage

### rtl/epcs_cfg_regs.sv
module epcs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [epcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [epcs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output epcs_pkg::t_cfg                      o_cfg
);
    import epcs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mfg_letters      <= 24'd0;
            r_cfg.product_code     <= 16'd65;
            r_cfg.week_number      <= 8'd5;
            r_cfg.year_number      <= 12'd2020;
            r_cfg.panel_size_index <= 6'd30;
            r_cfg.name_head        <= 64'd0;
            r_cfg.name_tail        <= 40'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MFG_LETTERS:      r_cfg.mfg_letters      <= i_cfg_data[23:0];
                CFG_PRODUCT_CODE:     r_cfg.product_code     <= i_cfg_data[15:0];
                CFG_WEEK_NUMBER:      r_cfg.week_number      <= i_cfg_data[7:0];
                CFG_YEAR_NUMBER:      r_cfg.year_number      <= i_cfg_data[11:0];
                CFG_PANEL_SIZE_INDEX: r_cfg.panel_size_index <= i_cfg_data[5:0];
                CFG_NAME_HEAD:        r_cfg.name_head        <= i_cfg_data[63:0];
                CFG_NAME_TAIL:        r_cfg.name_tail        <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/epcs_patch.sv
module epcs_patch (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  epcs_pkg::t_cfg      i_cfg,
    output epcs_pkg::t_result   o_result
);
    import epcs_pkg::*;

    localparam logic [7:0] POS_MFG_0    = 8'd8;
    localparam logic [7:0] POS_MFG_1    = 8'd9;
    localparam logic [7:0] POS_PROD_0   = 8'd10;
    localparam logic [7:0] POS_PROD_1   = 8'd11;
    localparam logic [7:0] POS_WEEK     = 8'd16;
    localparam logic [7:0] POS_YEAR     = 8'd17;
    localparam logic [7:0] POS_WIDTH    = 8'd21;
    localparam logic [7:0] POS_HEIGHT   = 8'd22;
    localparam logic [7:0] POS_DESC_LO  = 8'd54;
    localparam logic [7:0] POS_DESC_HI  = 8'd126;
    localparam logic [7:0] POS_SUM_LO   = 8'd127;
    localparam logic [7:0] POS_SUM_HI   = 8'd255;
    localparam logic [7:0] DESC_LEN     = 8'd18;
    localparam logic [7:0] TAG_NAME     = 8'hFC;
    localparam logic [7:0] NAME_END     = 8'h0A;
    localparam logic [7:0] NAME_PAD     = 8'h20;
    localparam logic [7:0] YEAR_BASE    = 8'(1990);
    localparam logic [7:0] YEAR_DEFAULT = 8'(2020 - 1990);
    localparam logic [7:0] WEEK_DEFAULT = 8'd6;

    logic [7:0] r_pos;
    logic [7:0] r_sum;
    logic       r_zero_seen;
    logic       r_name_match;
    logic       r_name_ended;

    logic [7:0] n_pos;
    logic [7:0] n_sum;
    logic       n_zero_seen;
    logic       n_name_match;
    logic       n_name_ended;

    logic [7:0]                  b;
    logic [7:0]                  d;
    logic [4:0]                  off;
    logic [3:0]                  name_idx;
    logic [7:0]                  name_c;
    logic [NAME_CHARS-1:0][7:0]  name_bytes;
    logic [15:0]                 panel_wh;
    logic                        in_desc;
    logic                        sum_pos;

    assign name_bytes = {i_cfg.name_tail, i_cfg.name_head};
    assign panel_wh   = panel_size(i_cfg.panel_size_index);
    assign in_desc    = (r_pos >= POS_DESC_LO) && (r_pos < POS_DESC_HI);
    assign sum_pos    = (r_pos == POS_SUM_LO) || (r_pos == POS_SUM_HI);
    assign d          = r_pos - POS_DESC_LO;

    // Offset within the 18-byte descriptor: at most three subtractions
    always_comb begin
        if (d < DESC_LEN) begin
            off = d[4:0];
        end else if (d < 8'(2 * 18)) begin
            off = 5'(d - DESC_LEN);
        end else if (d < 8'(3 * 18)) begin
            off = 5'(d - 8'(2 * 18));
        end else begin
            off = 5'(d - 8'(3 * 18));
        end
    end

    assign name_idx = 4'(off - 5'd5);
    assign name_c   = name_bytes[name_idx];

    always_comb begin
        b            = i_data_byte;
        n_zero_seen  = r_zero_seen;
        n_name_match = r_name_match;
        n_name_ended = r_name_ended;

        // Only the low five bits of each letter survive the packing, and
        // subtracting 64 leaves them untouched.
        unique case (r_pos)
            POS_MFG_0:  b = {1'b0, i_cfg.mfg_letters[4:0], i_cfg.mfg_letters[12:11]};
            POS_MFG_1:  b = {i_cfg.mfg_letters[10:8], i_cfg.mfg_letters[20:16]};
            POS_PROD_0: b = i_cfg.product_code[7:0];
            POS_PROD_1: b = i_cfg.product_code[15:8];
            POS_WEEK:   b = (i_cfg.week_number != 8'd0) ? i_cfg.week_number : WEEK_DEFAULT;
            POS_YEAR:   b = (i_cfg.year_number != 12'd0)
                            ? (i_cfg.year_number[7:0] - YEAR_BASE) : YEAR_DEFAULT;
            POS_WIDTH:  b = panel_wh[15:8];
            POS_HEIGHT: b = panel_wh[7:0];
            default: ;
        endcase

        if (in_desc) begin
            if (off == 5'd0) begin
                n_zero_seen  = (i_data_byte == 8'd0);
                n_name_match = 1'b0;
                n_name_ended = 1'b0;
            end else if (off == 5'd1) begin
                n_zero_seen  = r_zero_seen && (i_data_byte == 8'd0);
            end else if (off == 5'd3) begin
                n_name_match = r_zero_seen && (i_data_byte == TAG_NAME);
            end else if ((off >= 5'd5) && r_name_match) begin
                if (!r_name_ended && (name_c != 8'd0)) begin
                    b = name_c;
                end else begin
                    b            = r_name_ended ? NAME_PAD : NAME_END;
                    n_name_ended = 1'b1;
                end
            end
        end

        if (sum_pos) begin
            b     = 8'd0 - r_sum;
            n_sum = 8'd0;
        end else begin
            n_sum = r_sum + b;
        end

        n_pos = r_pos + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 8'd0;
            r_sum        <= 8'd0;
            r_zero_seen  <= 1'b0;
            r_name_match <= 1'b0;
            r_name_ended <= 1'b0;
        end else if (i_accept) begin
            r_pos        <= n_pos;
            r_sum        <= n_sum;
            r_zero_seen  <= n_zero_seen;
            r_name_match <= n_name_match;
            r_name_ended <= n_name_ended;
        end
    end

    assign o_result.out_byte   = b;
    assign o_result.image_last = (r_pos == POS_SUM_HI);

endmodule

### rtl/epcs_out_buf.sv
module epcs_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  epcs_pkg::t_result   i_result,
    input  logic                i_out_stall,
    output logic                o_full,
    output logic                o_out_valid,
    output epcs_pkg::t_result   o_result
);
    import epcs_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end
    end

    // Payload: advance skid into output, else load the new request
    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (i_push && (pop || !r_out_valid)) begin
            r_out <= i_result;
        end
        if (i_push && r_out_valid && !pop) begin
            r_skid <= i_result;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

### rtl/edid_patch_checksum_stream.sv
// EDID patcher: feed a 256-byte EDID image one byte per request in offset
// order and the block returns each byte at the same offset, patched. It keeps
// its own byte position (reset to offset 0, wrapping after offset 255), so
// images must be sent whole. Offsets 8-9 get the packed manufacturer ID,
// 10-11 the product code, 16-17 week and year (zero selects week 6 and year
// 2020), 21-22 panel width and height in cm from a fixed table (indices above
// 33 give 247 by 107). In the four first-block descriptors that start 00 00
// with tag 0xFC the 13 name bytes are replaced by the configured name, ended
// by 0x0A and padded with 0x20. Offsets 127 and 255 are replaced by the
// checksum of their half; o_image_last marks offset 255. One byte is taken
// per cycle unless the skid stage is full: the patch logic and 8-bit checksum
// add sit between the position and checksum registers and a result register,
// with a one-entry skid stage behind it, so a byte is accepted while a result
// waits. Write configuration only while the stream is idle.
module edid_patch_checksum_stream (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [epcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [epcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_image_last
);
    import epcs_pkg::*;

    t_cfg    cfg;
    t_result patched;
    t_result result;
    logic    buf_full;
    logic    accept;

    // Accept a request whenever the skid stage has room
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    epcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Patch the byte at the current position and advance position/checksum
    epcs_patch u_patch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_cfg       (cfg),
        .o_result    (patched)
    );

    // Hold results until the downstream side takes them
    epcs_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (patched),
        .i_out_stall (i_out_stall),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_out_byte   = result.out_byte;
    assign o_image_last = result.image_last;

endmodule
